@@ hdl/hscf_pkg.sv @@
// Package for the handshake serial character framer.
// Holds the transaction types and framing constants; depends on nothing.
`timescale 1ns / 1ps

package hscf_pkg;

    localparam int STUFF_PERIOD   = 4;
    localparam int PREAMBLE_ZEROS = 5;
    localparam int CHAR_BITS      = 10;
    localparam int POS_MAX        = (PREAMBLE_ZEROS > CHAR_BITS) ? PREAMBLE_ZEROS : CHAR_BITS;
    localparam int POS_W          = $clog2(POS_MAX + 1);
    localparam int CNT_W          = $clog2(STUFF_PERIOD);

    localparam logic REQ_CONNECT = 1'b0;
    localparam logic REQ_CHAR    = 1'b1;

    typedef struct packed {
        logic       req_type;
        logic [7:0] char_code;
    } t_req;

    typedef struct packed {
        logic line_bit;
        logic last_bit;
    } t_res;

endpackage

@@ hdl/handshake_serial_char_framer_core.sv @@
// Top level of the handshake serial character framer.
// Uses hscf_pkg for the transaction types and framing constants.
// How to use this block:
// Requests arrive on the input channel (i_in_valid, o_in_stall, i_in_data) and line bits
// leave on the output channel (o_out_valid, i_out_stall, o_out_data), one bit per
// transaction, with last_bit set on the final bit of each request.
// A connect request yields a 1 and then the preamble zeros (6 transactions) and clears
// the stuffing count. A character request yields the start bits 1 and 0 and the eight
// data bits, most significant first, with an extra 1 after every fourth counted bit,
// giving 12 or 13 transactions.
// An accepted request waits in a one-entry holding register and enters the serialiser
// once the serialiser is idle or is emitting the final bit of the current request.
// The serialiser emits one bit per cycle while the receiver does not stall, so the bits
// of a waiting request (6, or 12 or 13) follow those of the previous one without a gap.
// o_in_stall is high while the holding register is full.
// When the receiver stalls, the output register holds its bit and the serialiser waits.
// Reset empties the holding and output registers, stops the serialiser and clears
// the stuffing count.
`timescale 1ns / 1ps

module handshake_serial_char_framer_core (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_stall,
    input  hscf_pkg::t_req i_in_data,
    output logic          o_out_valid,
    input  logic          i_out_stall,
    output hscf_pkg::t_res o_out_data
);

    logic                       r_pend_valid;
    hscf_pkg::t_req             r_pend;
    logic                       r_busy;
    hscf_pkg::t_req             r_cur;
    logic [hscf_pkg::POS_W-1:0] r_pos;
    logic [hscf_pkg::CNT_W-1:0] r_stuff_count;
    logic                       r_stuff_pend;
    logic                       r_out_valid;
    hscf_pkg::t_res             r_out;

    logic                       accept;
    logic                       advance;
    logic                       load;
    logic                       gen_bit;
    logic                       gen_last;
    logic                       cnt_wrap;
    logic [hscf_pkg::POS_W-1:0] bit_sel;

    assign accept   = i_in_valid && !r_pend_valid;
    assign advance  = r_busy && (!r_out_valid || !i_out_stall);
    assign cnt_wrap = (r_stuff_count == hscf_pkg::CNT_W'(hscf_pkg::STUFF_PERIOD - 1));
    assign bit_sel  = hscf_pkg::POS_W'(hscf_pkg::CHAR_BITS - 1) - r_pos;

    always_comb begin
        gen_bit  = 1'b0;
        gen_last = 1'b0;
        if (r_cur.req_type == hscf_pkg::REQ_CONNECT) begin
            gen_bit  = (r_pos == '0);
            gen_last = (r_pos == hscf_pkg::POS_W'(hscf_pkg::PREAMBLE_ZEROS));
        end else if (r_stuff_pend) begin
            gen_bit  = 1'b1;
            gen_last = (r_pos == hscf_pkg::POS_W'(hscf_pkg::CHAR_BITS));
        end else begin
            if (r_pos == '0) begin
                gen_bit = 1'b1;
            end else if (r_pos == hscf_pkg::POS_W'(1)) begin
                gen_bit = 1'b0;
            end else begin
                gen_bit = r_cur.char_code[bit_sel[2:0]];
            end
            gen_last = (r_pos == hscf_pkg::POS_W'(hscf_pkg::CHAR_BITS - 1)) && !cnt_wrap;
        end
    end

    assign load = r_pend_valid && (!r_busy || (advance && gen_last));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend_valid  <= 1'b0;
            r_busy        <= 1'b0;
            r_pos         <= '0;
            r_stuff_count <= '0;
            r_stuff_pend  <= 1'b0;
            r_out_valid   <= 1'b0;
        end else begin
            if (accept) begin
                r_pend_valid <= 1'b1;
                r_pend       <= i_in_data;
            end else if (load) begin
                r_pend_valid <= 1'b0;
            end

            if (advance) begin
                r_out_valid    <= 1'b1;
                r_out.line_bit <= gen_bit;
                r_out.last_bit <= gen_last;
                if (r_cur.req_type == hscf_pkg::REQ_CONNECT) begin
                    if (gen_last) begin
                        r_stuff_count <= '0;
                    end
                end else if (r_stuff_pend) begin
                    r_stuff_pend <= 1'b0;
                end else begin
                    if (cnt_wrap) begin
                        r_stuff_count <= '0;
                        r_stuff_pend  <= 1'b1;
                    end else begin
                        r_stuff_count <= r_stuff_count + hscf_pkg::CNT_W'(1);
                    end
                end
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end

            if (load) begin
                r_busy <= 1'b1;
                r_cur  <= r_pend;
                r_pos  <= '0;
            end else if (advance) begin
                if (gen_last) begin
                    r_busy <= 1'b0;
                end
                if (!r_stuff_pend) begin
                    r_pos <= r_pos + hscf_pkg::POS_W'(1);
                end
            end
        end
    end

    assign o_in_stall  = r_pend_valid;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    a_pend_filled: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> r_pend_valid)
        else $error("Accepted request did not reach the holding register.");

    a_stuff_in_char: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_stuff_pend |-> (r_busy && r_cur.req_type == hscf_pkg::REQ_CHAR))
        else $error("Stuff bit pending outside a character request.");

    a_connect_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (advance && gen_last && r_cur.req_type == hscf_pkg::REQ_CONNECT)
        |=> (r_stuff_count == '0))
        else $error("Connect request did not clear the stuffing count.");

    a_out_bit_on_advance: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        advance |=> r_out_valid)
        else $error("Serialised bit was not presented on the output.");

endmodule
